// File: rtl/rras_pkg.sv
// Shared types, widths and codes for the rectangle region add/subtract unit.
// No dependencies; every other file of the block but rras_ram imports this package.
package rras_pkg;

	localparam int RECT_CAPACITY = 16;
	localparam int IDX_W = (RECT_CAPACITY > 1) ? $clog2(RECT_CAPACITY) : 1;
	localparam int CNT_W = $clog2(RECT_CAPACITY + 1);
	localparam int ADDR_W = IDX_W + 1;
	localparam int RAM_DEPTH = 2 << IDX_W;

	localparam int COORD_W = 32;
	localparam int SIZE_W = 31;
	localparam int SPAN_W = 33;
	localparam int EDGE_W = 34;
	localparam int CMD_IDX_W = 4;
	localparam int OUT_CNT_W = 5;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;

	localparam logic [1:0] SPAN_ADD = 2'd0;
	localparam logic [1:0] SPAN_SUB = 2'd1;
	localparam logic [1:0] SPAN_MAX = 2'd2;
	localparam logic [1:0] SPAN_MIN = 2'd3;

	typedef logic signed [EDGE_W-1:0] edge_t;
	typedef logic signed [SPAN_W-1:0] span_t;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [SIZE_W-1:0] size_t;

	typedef struct packed {
		size_t  h;
		size_t  w;
		coord_t y;
		coord_t x;
	} rect_entry_t;

	typedef struct packed {
		logic [1:0] op;
		edge_t      a0;
		edge_t      b0;
		edge_t      a1;
		edge_t      b1;
	} span_req_t;

	typedef struct packed {
		edge_t r0;
		edge_t r1;
		logic  lt0;
		logic  lt1;
	} span_rsp_t;

endpackage

// File: rtl/rras_cmd_if.sv
// Command channel of the rectangle region unit: valid/ready and one command word.
// Depends on rras_pkg for field widths.
interface rras_cmd_if;
	import rras_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [1:0]           opcode;
	coord_t               rect_x;
	coord_t               rect_y;
	coord_t               rect_width;
	coord_t               rect_height;
	logic [CMD_IDX_W-1:0] read_index;

	modport source (
		output valid, opcode, rect_x, rect_y, rect_width, rect_height, read_index,
		input  ready
	);

	modport sink (
		input  valid, opcode, rect_x, rect_y, rect_width, rect_height, read_index,
		output ready
	);

endinterface

// File: rtl/rras_rsp_if.sv
// Response channel of the rectangle region unit: valid/ready and one result word.
// Depends on rras_pkg for field widths.
interface rras_rsp_if;
	import rras_pkg::*;

	logic                 valid;
	logic                 ready;
	coord_t               out_x;
	coord_t               out_y;
	size_t                out_width;
	size_t                out_height;
	logic [OUT_CNT_W-1:0] entry_count;
	logic [1:0]           status;

	modport source (
		output valid, out_x, out_y, out_width, out_height, entry_count, status,
		input  ready
	);

	modport sink (
		input  valid, out_x, out_y, out_width, out_height, entry_count, status,
		output ready
	);

endinterface

// File: rtl/rras_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rras_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

// File: rtl/rras_span_unit.sv
// Shared two-lane edge arithmetic unit: add, subtract, max and min on 34-bit values.
// Depends on rras_pkg for the request/response structs and op codes.
module rras_span_unit (
	input  rras_pkg::span_req_t req,
	output rras_pkg::span_rsp_t rsp
);
	import rras_pkg::*;

	edge_t diff0;
	edge_t diff1;

	function automatic edge_t lane(logic [1:0] op, edge_t a, edge_t b);
		edge_t d;
		edge_t s;
		d = a - b;
		s = a + b;
		case (op)
			SPAN_ADD: return s;
			SPAN_SUB: return d;
			SPAN_MAX: return d[EDGE_W-1] ? b : a;
			SPAN_MIN: return d[EDGE_W-1] ? a : b;
			default:  return s;
		endcase
	endfunction

	assign diff0 = req.a0 - req.b0;
	assign diff1 = req.a1 - req.b1;

	always_comb begin
		rsp.r0  = lane(req.op, req.a0, req.b0);
		rsp.r1  = lane(req.op, req.a1, req.b1);
		rsp.lt0 = diff0[EDGE_W-1];
		rsp.lt1 = diff1[EDGE_W-1];
	end

endmodule

// File: rtl/rectangle_region_add_subtract_unit.sv
// Rectangle region store: top level with the sequencer, entry RAM and edge unit.
// Depends on rras_pkg, rras_cmd_if, rras_rsp_if, rras_ram and rras_span_unit.
//
// The unit holds a region as an ordered list of up to RECT_CAPACITY axis-aligned
// rectangles in two banks of one RAM, and takes one command word at a time: add,
// subtract or read. Every command returns exactly one result word. Sizes are
// normalized first (negative width or height moves the origin back) on the
// shared two-lane edge unit, in S_NORM_A and S_NORM_B. A subtract whose cut is
// empty after normalization ends there. Any other subtract visits each stored
// rectangle and copies it to the other bank when it misses the cut, or splits
// it when it overlaps (edge sums, max/min clipping, overlap test, piece sizes,
// then up to four piece writes through the single RAM write port).
// The result register load waits while the previous result word is still
// stalled. The scan result goes to the other bank, which then becomes
// active. cmd.ready is high only while the sequencer is idle; a finished result
// waits in the output register, so the next command can be taken before the
// previous result word has been drained. There is no clearing pass: entries
// are only read below the fill count, and those have always been written.
module rectangle_region_add_subtract_unit (
	input logic      clk,
	input logic      arst_n,
	rras_cmd_if.sink cmd,
	rras_rsp_if.source rsp
);
	import rras_pkg::*;

	localparam logic [4:0] S_IDLE      = 5'd0;
	localparam logic [4:0] S_NORM_A    = 5'd1;
	localparam logic [4:0] S_NORM_B    = 5'd2;
	localparam logic [4:0] S_CUT_EDGE  = 5'd3;
	localparam logic [4:0] S_APPEND    = 5'd4;
	localparam logic [4:0] S_READ_WAIT = 5'd5;
	localparam logic [4:0] S_SCAN_RD   = 5'd6;
	localparam logic [4:0] S_EDGE_A    = 5'd7;
	localparam logic [4:0] S_EDGE_B    = 5'd8;
	localparam logic [4:0] S_EDGE_C    = 5'd9;
	localparam logic [4:0] S_EDGE_D    = 5'd10;
	localparam logic [4:0] S_KEEP      = 5'd11;
	localparam logic [4:0] S_PIECE_A   = 5'd12;
	localparam logic [4:0] S_PIECE_B   = 5'd13;
	localparam logic [4:0] S_PIECE_C   = 5'd14;
	localparam logic [4:0] S_PUT_LEFT  = 5'd15;
	localparam logic [4:0] S_PUT_RIGHT = 5'd16;
	localparam logic [4:0] S_SUB_END   = 5'd17;
	localparam logic [4:0] S_DONE      = 5'd18;

	// Sequencer and region bookkeeping
	logic [4:0]       state_q;
	logic             bank_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_q;      // fill of the destination bank during a subtract
	logic [CNT_W-1:0] i_q;      // source entry being visited
	logic             ok_q;     // cleared when an entry or piece had to be dropped
	logic [1:0]       status_q;
	logic             rsp_valid_q;

	// Command word, normalized in place
	logic [1:0]           op_q;
	logic [CMD_IDX_W-1:0] idx_q;
	coord_t               cut_x_q;
	coord_t               cut_y_q;
	coord_t               cut_w_q;
	coord_t               cut_h_q;
	span_t                cut_r_q;
	span_t                cut_b_q;

	// Stored rectangle under inspection and its clipped edges
	rect_entry_t ent_q;
	span_t       rr_q;
	span_t       bb_q;
	span_t       ol_q;
	span_t       ot_q;
	span_t       orr_q;
	span_t       ob_q;

	// Piece sizes with their non-empty flags
	size_t h1_q;
	size_t h2_q;
	size_t w3_q;
	size_t w4_q;
	size_t h34_q;
	logic  h1_nz_q;
	logic  h2_nz_q;
	logic  w3_nz_q;
	logic  w4_nz_q;
	logic  h34_nz_q;

	// Read result and output register
	rect_entry_t          res_q;
	rect_entry_t          out_q;
	logic [OUT_CNT_W-1:0] out_count_q;
	logic [1:0]           out_status_q;

	span_req_t             span_req;
	span_rsp_t             span_rsp;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic                  rd_en;
	logic [ADDR_W-1:0]     rd_addr;
	logic [$bits(rect_entry_t)-1:0] rd_data;
	rect_entry_t           rd_ent;
	logic                  put_en;
	rect_entry_t           put_ent;
	logic [CNT_W-1:0]      put_fill;
	logic                  put_bank;
	logic                  put_full;
	logic                  cut_empty;
	logic                  scan_more;
	logic                  read_ok;
	logic                  overlap;
	logic                  rsp_load;

	function automatic edge_t sx32(coord_t v);
		return {{(EDGE_W - COORD_W){v[COORD_W-1]}}, v};
	endfunction

	function automatic edge_t sx33(span_t v);
		return {{(EDGE_W - SPAN_W){v[SPAN_W-1]}}, v};
	endfunction

	function automatic edge_t zx31(size_t v);
		return {{(EDGE_W - SIZE_W){1'b0}}, v};
	endfunction

	// A piece is kept only when its size is strictly positive.
	function automatic logic positive(edge_t v);
		return !v[EDGE_W-1] && (v != '0);
	endfunction

	assign rd_ent    = rect_entry_t'(rd_data);
	assign cut_empty = (cut_w_q <= 32'sd0) || (cut_h_q <= 32'sd0);
	assign scan_more = i_q < count_q;
	assign read_ok   = 32'(idx_q) < 32'(count_q);
	assign overlap   = span_rsp.lt0 && span_rsp.lt1;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	rras_span_unit u_span (
		.req(span_req),
		.rsp(span_rsp)
	);

	rras_ram #(
		.WIDTH($bits(rect_entry_t)),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(put_ent),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Operand steering for the shared edge unit
	always_comb begin
		span_req    = '0;
		span_req.op = SPAN_ADD;
		case (state_q)
			S_NORM_A, S_CUT_EDGE: begin
				span_req.a0 = sx32(cut_x_q);
				span_req.b0 = sx32(cut_w_q);
				span_req.a1 = sx32(cut_y_q);
				span_req.b1 = sx32(cut_h_q);
			end
			S_NORM_B: begin
				span_req.op = SPAN_SUB;
				span_req.b0 = sx32(cut_w_q);
				span_req.b1 = sx32(cut_h_q);
			end
			S_EDGE_A: begin
				span_req.a0 = sx32(rd_ent.x);
				span_req.b0 = zx31(rd_ent.w);
				span_req.a1 = sx32(rd_ent.y);
				span_req.b1 = zx31(rd_ent.h);
			end
			S_EDGE_B: begin
				span_req.op = SPAN_MAX;
				span_req.a0 = sx32(ent_q.x);
				span_req.b0 = sx32(cut_x_q);
				span_req.a1 = sx32(ent_q.y);
				span_req.b1 = sx32(cut_y_q);
			end
			S_EDGE_C: begin
				span_req.op = SPAN_MIN;
				span_req.a0 = sx33(rr_q);
				span_req.b0 = sx33(cut_r_q);
				span_req.a1 = sx33(bb_q);
				span_req.b1 = sx33(cut_b_q);
			end
			S_EDGE_D: begin
				span_req.op = SPAN_SUB;
				span_req.a0 = sx33(ol_q);
				span_req.b0 = sx33(orr_q);
				span_req.a1 = sx33(ot_q);
				span_req.b1 = sx33(ob_q);
			end
			S_PIECE_A: begin
				span_req.op = SPAN_SUB;
				span_req.a0 = sx33(ot_q);
				span_req.b0 = sx32(ent_q.y);
				span_req.a1 = sx33(bb_q);
				span_req.b1 = sx33(ob_q);
			end
			S_PIECE_B: begin
				span_req.op = SPAN_SUB;
				span_req.a0 = sx33(ol_q);
				span_req.b0 = sx32(ent_q.x);
				span_req.a1 = sx33(rr_q);
				span_req.b1 = sx33(orr_q);
			end
			S_PIECE_C: begin
				span_req.op = SPAN_SUB;
				span_req.a0 = sx33(ob_q);
				span_req.b0 = sx33(ot_q);
			end
			default: begin
			end
		endcase
	end

	// Entry writes: append to the active bank, kept entries and pieces go to the other bank
	always_comb begin
		put_en  = 1'b0;
		put_ent = ent_q;
		case (state_q)
			S_APPEND: begin
				put_en    = !cut_empty;
				put_ent.x = cut_x_q;
				put_ent.y = cut_y_q;
				put_ent.w = cut_w_q[SIZE_W-1:0];
				put_ent.h = cut_h_q[SIZE_W-1:0];
			end
			S_KEEP: begin
				put_en = 1'b1;
			end
			S_PIECE_B: begin
				put_en    = h1_nz_q;
				put_ent.h = h1_q;
			end
			S_PIECE_C: begin
				put_en    = h2_nz_q;
				put_ent.y = ob_q[COORD_W-1:0];
				put_ent.h = h2_q;
			end
			S_PUT_LEFT: begin
				put_en    = w3_nz_q && h34_nz_q;
				put_ent.y = ot_q[COORD_W-1:0];
				put_ent.w = w3_q;
				put_ent.h = h34_q;
			end
			S_PUT_RIGHT: begin
				put_en    = w4_nz_q && h34_nz_q;
				put_ent.x = orr_q[COORD_W-1:0];
				put_ent.y = ot_q[COORD_W-1:0];
				put_ent.w = w4_q;
				put_ent.h = h34_q;
			end
			default: begin
			end
		endcase
	end

	assign put_fill = (state_q == S_APPEND) ? count_q : n_q;
	assign put_bank = (state_q == S_APPEND) ? bank_q : !bank_q;
	assign put_full = put_fill >= CNT_W'(RECT_CAPACITY);
	assign wr_en    = put_en && !put_full;
	assign wr_addr  = {put_bank, put_fill[IDX_W-1:0]};

	// Entry reads: the scan walks the active bank, a read fetches one index
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_SCAN_RD: begin
				rd_en   = scan_more;
				rd_addr = {bank_q, i_q[IDX_W-1:0]};
			end
			S_NORM_B: begin
				rd_en   = (op_q == OP_READ) && read_ok;
				rd_addr = {bank_q, IDX_W'(idx_q)};
			end
			default: begin
			end
		endcase
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bank_q      <= 1'b0;
			count_q     <= '0;
			n_q         <= '0;
			i_q         <= '0;
			ok_q        <= 1'b1;
			status_q    <= ST_OK;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			// Scan writes: advance the destination fill or flag the drop
			if (put_en && state_q != S_APPEND) begin
				if (put_full) begin
					ok_q <= 1'b0;
				end else begin
					n_q <= n_q + CNT_W'(1);
				end
			end

			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						status_q <= ST_OK;
						state_q  <= S_NORM_A;
					end
				end
				S_NORM_A: begin
					state_q <= S_NORM_B;
				end
				S_NORM_B: begin
					case (op_q)
						OP_ADD: state_q <= S_APPEND;
						OP_SUB: state_q <= S_CUT_EDGE;
						OP_READ: begin
							if (read_ok) begin
								state_q <= S_READ_WAIT;
							end else begin
								status_q <= ST_BAD_INDEX;
								state_q  <= S_DONE;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_APPEND: begin
					if (put_en) begin
						if (put_full) begin
							status_q <= ST_OVERFLOW;
						end else begin
							count_q <= count_q + CNT_W'(1);
						end
					end
					state_q <= S_DONE;
				end
				S_CUT_EDGE: begin
					if (cut_empty) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= '0;
						n_q     <= '0;
						ok_q    <= 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_READ_WAIT: begin
					state_q <= S_DONE;
				end
				S_SCAN_RD: begin
					state_q <= scan_more ? S_EDGE_A : S_SUB_END;
				end
				S_EDGE_A: begin
					state_q <= S_EDGE_B;
				end
				S_EDGE_B: begin
					state_q <= S_EDGE_C;
				end
				S_EDGE_C: begin
					state_q <= S_EDGE_D;
				end
				S_EDGE_D: begin
					state_q <= overlap ? S_PIECE_A : S_KEEP;
				end
				S_KEEP: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= S_SCAN_RD;
				end
				S_PIECE_A: begin
					state_q <= S_PIECE_B;
				end
				S_PIECE_B: begin
					state_q <= S_PIECE_C;
				end
				S_PIECE_C: begin
					state_q <= S_PUT_LEFT;
				end
				S_PUT_LEFT: begin
					state_q <= S_PUT_RIGHT;
				end
				S_PUT_RIGHT: begin
					i_q     <= i_q + CNT_W'(1);
					state_q <= S_SCAN_RD;
				end
				S_SUB_END: begin
					bank_q   <= !bank_q;
					count_q  <= n_q;
					status_q <= ok_q ? ST_OK : ST_OVERFLOW;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					op_q    <= cmd.opcode;
					idx_q   <= cmd.read_index;
					cut_x_q <= cmd.rect_x;
					cut_y_q <= cmd.rect_y;
					cut_w_q <= cmd.rect_width;
					cut_h_q <= cmd.rect_height;
					res_q   <= '0;
				end
			end
			S_NORM_A: begin
				// Negative size: move the origin back, wrapping at 32 bits
				if (cut_w_q[COORD_W-1]) begin
					cut_x_q <= span_rsp.r0[COORD_W-1:0];
				end
				if (cut_h_q[COORD_W-1]) begin
					cut_y_q <= span_rsp.r1[COORD_W-1:0];
				end
			end
			S_NORM_B: begin
				if (cut_w_q[COORD_W-1]) begin
					cut_w_q <= span_rsp.r0[COORD_W-1:0];
				end
				if (cut_h_q[COORD_W-1]) begin
					cut_h_q <= span_rsp.r1[COORD_W-1:0];
				end
			end
			S_CUT_EDGE: begin
				cut_r_q <= span_rsp.r0[SPAN_W-1:0];
				cut_b_q <= span_rsp.r1[SPAN_W-1:0];
			end
			S_READ_WAIT: begin
				res_q <= rd_ent;
			end
			S_EDGE_A: begin
				ent_q <= rd_ent;
				rr_q  <= span_rsp.r0[SPAN_W-1:0];
				bb_q  <= span_rsp.r1[SPAN_W-1:0];
			end
			S_EDGE_B: begin
				ol_q <= span_rsp.r0[SPAN_W-1:0];
				ot_q <= span_rsp.r1[SPAN_W-1:0];
			end
			S_EDGE_C: begin
				orr_q <= span_rsp.r0[SPAN_W-1:0];
				ob_q  <= span_rsp.r1[SPAN_W-1:0];
			end
			S_PIECE_A: begin
				h1_q    <= span_rsp.r0[SIZE_W-1:0];
				h1_nz_q <= positive(span_rsp.r0);
				h2_q    <= span_rsp.r1[SIZE_W-1:0];
				h2_nz_q <= positive(span_rsp.r1);
			end
			S_PIECE_B: begin
				w3_q    <= span_rsp.r0[SIZE_W-1:0];
				w3_nz_q <= positive(span_rsp.r0);
				w4_q    <= span_rsp.r1[SIZE_W-1:0];
				w4_nz_q <= positive(span_rsp.r1);
			end
			S_PIECE_C: begin
				h34_q    <= span_rsp.r0[SIZE_W-1:0];
				h34_nz_q <= positive(span_rsp.r0);
			end
			default: begin
			end
		endcase

		if (rsp_load) begin
			out_q        <= res_q;
			out_count_q  <= OUT_CNT_W'(count_q);
			out_status_q <= status_q;
		end
	end

	assign cmd.ready       = (state_q == S_IDLE);
	assign rsp.valid       = rsp_valid_q;
	assign rsp.out_x       = out_q.x;
	assign rsp.out_y       = out_q.y;
	assign rsp.out_width   = out_q.w;
	assign rsp.out_height  = out_q.h;
	assign rsp.entry_count = out_count_q;
	assign rsp.status      = out_status_q;

endmodule

// File: rtl/rras_checker.sv
// Port-level assertions for the rectangle region unit, bound to its top level.
// Depends on rras_pkg and rectangle_region_add_subtract_unit.
module rras_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cmd_valid,
	input logic                           cmd_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input rras_pkg::coord_t               out_x,
	input rras_pkg::coord_t               out_y,
	input rras_pkg::size_t                out_width,
	input rras_pkg::size_t                out_height,
	input logic [rras_pkg::OUT_CNT_W-1:0] entry_count,
	input logic [1:0]                     status
);
	import rras_pkg::*;

	// A stalled result word stays valid with its status and entry count unchanged.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(entry_count))
		else $error("result word changed while stalled");

	// Each command keeps the unit busy for at least the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("command accepted on back-to-back cycles");

	// A rejected read index returns an all-zero rectangle.
	a_bad_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_BAD_INDEX |->
		out_x == '0 && out_y == '0 && out_width == '0 && out_height == '0)
		else $error("bad read index returned rectangle data");

	// A rectangle shows only from a good read, and stored rectangles are never empty.
	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (out_width != '0 || out_height != '0) |->
		out_width != '0 && out_height != '0 && status == ST_OK)
		else $error("empty or misflagged rectangle returned");

endmodule

bind rectangle_region_add_subtract_unit rras_checker u_rras_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.out_x      (rsp.out_x),
	.out_y      (rsp.out_y),
	.out_width  (rsp.out_width),
	.out_height (rsp.out_height),
	.entry_count(rsp.entry_count),
	.status     (rsp.status)
);
